[sv/lfia_pkg.sv]
// Package for the lowest free ID allocator.
// Request/response structs, request and status codes, sequencer states, word encoder.
// No dependencies.
`default_nettype none
package lfia_pkg;

  localparam int ID_COUNT = 256;
  localparam int ID_W     = 8;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int WORD_CNT = ID_COUNT / WORD_W;
  localparam int WIDX_W   = 3;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_CLAIM   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_IN_USE    = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] req_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic [1:0]      status;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_REL,
    S_SCAN_FREE
  } state_t;

  // position of the lowest set bit; 0 for an empty word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

[sv/lowest_free_id_allocator_top.sv]
// Top level of the lowest free ID allocator: maps, fresh mark and scan sequencer.
// Depends on lfia_pkg.
`default_nettype none
// Claim and release requests are answered directly: the response appears with done in
// the cycle after start. An allocate request scans the 256-bit maps one 32-bit word
// per cycle through a single priority encoder: first the released map from word 0,
// then, if nothing was released and the fresh mark has not passed the top, the free
// map from the word holding the fresh mark upward, until a hit or the last word.
// busy is high while the scan runs and start is ignored then. done is a one-cycle
// strobe with the response on rsp; the receiver cannot stall it.
module lowest_free_id_allocator_top (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  input  lfia_pkg::req_t  req,
  output logic            busy,
  output logic            done,
  output lfia_pkg::rsp_t  rsp
);

  lfia_pkg::state_t state, state_next;
  logic [lfia_pkg::ID_COUNT-1:0] in_use, in_use_next;
  logic [lfia_pkg::ID_COUNT-1:0] released, released_next;
  logic [lfia_pkg::ID_W:0]       fresh_mark, fresh_mark_next;
  logic [lfia_pkg::WIDX_W-1:0]   widx, widx_next;
  logic                          done_next;
  lfia_pkg::rsp_t                rsp_next;

  logic                          accept;
  logic [lfia_pkg::WORD_W-1:0]   free_mask;
  logic [lfia_pkg::WORD_W-1:0]   scan_word;
  logic                          hit;
  logic [lfia_pkg::ID_W-1:0]     hit_id;
  logic                          last_word;

  assign accept = start && (state == lfia_pkg::S_IDLE);
  assign busy   = (state != lfia_pkg::S_IDLE);

  always_comb begin
    for (int b = 0; b < lfia_pkg::WORD_W; b++) begin
      free_mask[b] = ({1'b0, widx, lfia_pkg::BIT_W'(b)} >= fresh_mark);
    end
  end

  // shared word encoder
  always_comb begin
    if (state == lfia_pkg::S_SCAN_REL) begin
      scan_word = released[widx*lfia_pkg::WORD_W +: lfia_pkg::WORD_W];
    end else begin
      scan_word = ~in_use[widx*lfia_pkg::WORD_W +: lfia_pkg::WORD_W] & free_mask;
    end
  end

  assign hit       = |scan_word;
  assign hit_id    = {widx, lfia_pkg::lowest_set(scan_word)};
  assign last_word = (widx == lfia_pkg::WIDX_W'(lfia_pkg::WORD_CNT - 1));

  // next state
  always_comb begin
    state_next = state;
    widx_next  = widx;
    case (state)
      lfia_pkg::S_IDLE: begin
        if (accept && req.kind == lfia_pkg::KIND_ALLOC) begin
          state_next = lfia_pkg::S_SCAN_REL;
          widx_next  = '0;
        end
      end
      lfia_pkg::S_SCAN_REL: begin
        if (hit) begin
          state_next = lfia_pkg::S_IDLE;
        end else if (last_word) begin
          if (fresh_mark[lfia_pkg::ID_W]) begin
            state_next = lfia_pkg::S_IDLE;
          end else begin
            state_next = lfia_pkg::S_SCAN_FREE;
            widx_next  = fresh_mark[lfia_pkg::ID_W-1:lfia_pkg::BIT_W];
          end
        end else begin
          widx_next = widx + 1'b1;
        end
      end
      lfia_pkg::S_SCAN_FREE: begin
        if (hit || last_word) begin
          state_next = lfia_pkg::S_IDLE;
        end else begin
          widx_next = widx + 1'b1;
        end
      end
      default: begin
        state_next = lfia_pkg::S_IDLE;
      end
    endcase
  end

  // map updates and response
  always_comb begin
    in_use_next     = in_use;
    released_next   = released;
    fresh_mark_next = fresh_mark;
    done_next       = 1'b0;
    rsp_next        = '{granted_id: '0, status: lfia_pkg::ST_IGNORED};
    case (state)
      lfia_pkg::S_IDLE: begin
        if (accept) begin
          case (req.kind)
            lfia_pkg::KIND_ALLOC: begin
            end
            lfia_pkg::KIND_CLAIM: begin
              done_next = 1'b1;
              if (req.req_id == '0) begin
                rsp_next.status = lfia_pkg::ST_IGNORED;
              end else if (in_use[req.req_id]) begin
                rsp_next.status = lfia_pkg::ST_IN_USE;
              end else begin
                in_use_next[req.req_id]   = 1'b1;
                released_next[req.req_id] = 1'b0;
                rsp_next.granted_id       = req.req_id;
                rsp_next.status           = lfia_pkg::ST_OK;
              end
            end
            lfia_pkg::KIND_RELEASE: begin
              done_next = 1'b1;
              if (req.req_id != '0) begin
                in_use_next[req.req_id]   = 1'b0;
                released_next[req.req_id] = 1'b1;
                rsp_next.granted_id       = req.req_id;
                rsp_next.status           = lfia_pkg::ST_OK;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      lfia_pkg::S_SCAN_REL: begin
        if (hit) begin
          released_next[hit_id] = 1'b0;
          in_use_next[hit_id]   = 1'b1;
          done_next             = 1'b1;
          rsp_next.granted_id   = hit_id;
          rsp_next.status       = lfia_pkg::ST_OK;
        end else if (last_word && fresh_mark[lfia_pkg::ID_W]) begin
          done_next       = 1'b1;
          rsp_next.status = lfia_pkg::ST_EXHAUSTED;
        end
      end
      lfia_pkg::S_SCAN_FREE: begin
        if (hit) begin
          in_use_next[hit_id] = 1'b1;
          fresh_mark_next     = {1'b0, hit_id} + 1'b1;
          done_next           = 1'b1;
          rsp_next.granted_id = hit_id;
          rsp_next.status     = lfia_pkg::ST_OK;
        end else if (last_word) begin
          done_next       = 1'b1;
          rsp_next.status = lfia_pkg::ST_EXHAUSTED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lfia_pkg::S_IDLE;
      in_use     <= '0;
      released   <= '0;
      fresh_mark <= (lfia_pkg::ID_W+1)'(1);
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      in_use     <= in_use_next;
      released   <= released_next;
      fresh_mark <= fresh_mark_next;
      done       <= done_next;
    end
    widx <= widx_next;
    rsp  <= rsp_next;
  end

endmodule
`default_nettype wire

[sv/lfia_checker.sv]
// Port-level checker for the lowest free ID allocator, bound to the top level.
// Depends on lfia_pkg and lowest_free_id_allocator_top.
`default_nettype none
module lfia_checker (
  input wire            clk,
  input wire            rst,
  input wire            start,
  input wire            busy,
  input wire            done,
  input lfia_pkg::rsp_t rsp
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response while busy");

  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("request neither answered nor in progress");

  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> busy || done)
    else $error("scan ended without response");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != lfia_pkg::ST_OK |-> rsp.granted_id == '0)
    else $error("failed request returned an ID");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == lfia_pkg::ST_OK |-> rsp.granted_id != '0)
    else $error("ok response with ID zero");

endmodule

bind lowest_free_id_allocator_top lfia_checker u_lfia_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire
